// ----- rtl/pia_pkg.sv -----
`default_nettype none
// ============================================================================
// pia_pkg: shared types and constants for the positional insert/delete array
// Field widths, request and status codes, controller states and the command
// and status bundles between the controller and the datapath.
// ============================================================================
package pia_pkg;

    // Default number of array entries
    localparam int DEPTH_DEF = 32;

    // Fixed field widths
    localparam int REQ_W     = 2;
    localparam int POS_W     = 6;
    localparam int ELEM_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int EIDX_W    = 5;
    localparam int CNT_OUT_W = 6;

    // Stream widths; the tdata widths are packed to whole bytes
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 48;

    // Most results a traverse gives
    localparam int MAX_TRAV = 32;

    typedef enum logic [REQ_W-1:0] {
        REQ_TRAVERSE = 2'd0,
        REQ_INSERT   = 2'd1,
        REQ_DELETE   = 2'd2
    } req_e_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } status_e_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_TRAV = 1'b1
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_req;   // take the request on the slave side
        logic emit_elem;  // emit the next traverse element
    } pia_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;   // output register can take a result this cycle
        logic trav_go;    // request on the bus is a traverse of a non-empty array
        logic emit_last;  // element about to be emitted is the final one
    } pia_stat_t;

endpackage : pia_pkg
`default_nettype wire

// ----- rtl/positional_insert_delete_array_core.sv -----
`default_nettype none
// ============================================================================
// positional_insert_delete_array_core: dense array with positional edits
// Top level joining the request sequencer and the cell datapath.
// ============================================================================
// Usage:
//   Slave stream carries requests: tuser is the request kind (traverse,
//   insert, delete), tdata the position and the value to insert. Master
//   stream carries results; tlast marks the final result of a request.
//   Insert and delete shift the cells at and above the position; their single
//   result sits in the output register the cycle after the transfer, and a new
//   request is taken every cycle while the master side keeps up. A traverse of
//   n stored elements emits min(n, 32) results, one per cycle as the master
//   side takes them, from the single cell read port; the first passes the
//   traverse state, then the output register. The slave side is held off until
//   the last. An empty traverse gives one result with the empty status.
//   Reset clears the element count, traverse index and output valid flag;
//   cell and payload registers are not reset; cells are read only once written.
//   When the receiver stalls, the result holds in the output register and
//   no further request or traverse element moves until it is taken.
// ============================================================================
module positional_insert_delete_array_core
#(
    parameter int DEPTH = pia_pkg::DEPTH_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // [5:0] position, [37:6] value, [39:38] zero
    input  wire logic [pia_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [1:0] req_type
    input  wire logic [pia_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [1:0] status, [33:2] element, [38:34] element_index,
    // [44:39] count_now, [47:45] zero
    output logic      [pia_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic                               m_axis_tlast
);
    import pia_pkg::*;

    pia_cmd_t  cmd;
    pia_stat_t stat;

    // Sequencer
    pia_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Cells, count and output register
    pia_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_axis_tdata),
        .s_tuser  (s_axis_tuser),
        .m_tready (m_axis_tready),
        .m_tvalid (m_axis_tvalid),
        .m_tdata  (m_axis_tdata),
        .m_tlast  (m_axis_tlast),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule : positional_insert_delete_array_core
`default_nettype wire

// ----- rtl/pia_ctrl.sv -----
`default_nettype none
// ============================================================================
// pia_ctrl: request sequencer
// Takes requests when the output register is free and walks a traverse one
// element per free output slot.
// ============================================================================
module pia_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire pia_pkg::pia_stat_t stat,
    output pia_pkg::pia_cmd_t       cmd
);
    import pia_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        s_ready       = 1'b0;
        cmd.load_req  = 1'b0;
        cmd.emit_elem = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_ready = stat.out_free;
                if (s_valid && stat.out_free)
                begin
                    cmd.load_req = 1'b1;
                    if (stat.trav_go)
                    begin
                        state_next = S_TRAV;
                    end
                end
            end
            S_TRAV:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_elem = 1'b1;
                    if (stat.emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule : pia_ctrl
`default_nettype wire

// ----- rtl/pia_datapath.sv -----
`default_nettype none
// ============================================================================
// pia_datapath: element cells, count and output register
// Each cell compares its own index with the request position and shifts in
// parallel with the others; a traverse reads one cell per emitted result.
// ============================================================================
module pia_datapath
#(
    parameter int DEPTH = pia_pkg::DEPTH_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [pia_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic [pia_pkg::S_TUSER_W-1:0] s_tuser,
    input  wire logic                          m_tready,
    output logic                               m_tvalid,
    output logic      [pia_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                               m_tlast,
    input  wire pia_pkg::pia_cmd_t             cmd,
    output pia_pkg::pia_stat_t                 stat
);
    import pia_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int TR_W  = (IDX_W < EIDX_W) ? IDX_W : EIDX_W;
    localparam int LIM_W = (CNT_W > EIDX_W + 1) ? CNT_W : EIDX_W + 1;

    // Element cells and count
    logic [ELEM_W-1:0]    cells_reg [DEPTH];
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [TR_W-1:0]      trav_idx_reg;
    logic [TR_W-1:0]      trav_idx_next;

    // Output register
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [STATUS_W-1:0]  out_status_next;
    logic [ELEM_W-1:0]    out_elem_reg;
    logic [ELEM_W-1:0]    out_elem_next;
    logic [EIDX_W-1:0]    out_idx_reg;
    logic [EIDX_W-1:0]    out_idx_next;
    logic [CNT_OUT_W-1:0] out_cnt_reg;
    logic [CNT_OUT_W-1:0] out_cnt_next;
    logic                 out_last_reg;
    logic                 out_last_next;

    // Request decode
    logic [REQ_W-1:0]     req;
    logic [POS_W-1:0]     pos;
    logic [ELEM_W-1:0]    val;
    logic [CMP_W-1:0]     pos_c;
    logic [CMP_W-1:0]     cnt_c;
    logic                 full;
    logic                 do_ins;
    logic                 do_del;
    logic                 trav_go;
    logic [STATUS_W-1:0]  res_status;
    logic [CNT_W-1:0]     count_after;

    // Traverse
    logic [ELEM_W-1:0]    rd_elem;
    logic [LIM_W-1:0]     cnt_l;
    logic [LIM_W-1:0]     trav_lim;
    logic                 emit_last;
    logic                 out_free;

    assign req   = s_tuser[REQ_W-1:0];
    assign pos   = s_tdata[POS_W-1:0];
    assign val   = s_tdata[POS_W +: ELEM_W];
    assign pos_c = CMP_W'(pos);
    assign cnt_c = CMP_W'(count_reg);
    assign full  = (count_reg == CNT_W'(DEPTH));

    // Check the request and work out its status and new count
    always_comb
    begin
        res_status  = ST_BAD_POS;
        do_ins      = 1'b0;
        do_del      = 1'b0;
        trav_go     = 1'b0;
        count_after = count_reg;
        unique case (req)
            REQ_TRAVERSE:
            begin
                if (count_reg == '0)
                begin
                    res_status = ST_EMPTY;
                end
                else
                begin
                    res_status = ST_OK;
                    trav_go    = 1'b1;
                end
            end
            REQ_INSERT:
            begin
                if (pos_c > cnt_c)
                begin
                    res_status = ST_BAD_POS;
                end
                else if (full)
                begin
                    res_status = ST_FULL;
                end
                else
                begin
                    res_status  = ST_OK;
                    do_ins      = 1'b1;
                    count_after = count_reg + CNT_W'(1);
                end
            end
            REQ_DELETE:
            begin
                if (pos_c >= cnt_c)
                begin
                    res_status = ST_BAD_POS;
                end
                else
                begin
                    res_status  = ST_OK;
                    do_del      = 1'b1;
                    count_after = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                res_status = ST_BAD_POS;
            end
        endcase
    end

    // Per-cell compare and shift
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [ELEM_W-1:0] from_below;
        logic [ELEM_W-1:0] from_above;

        if (i == 0)
        begin : g_first
            assign from_below = val;
        end
        else
        begin : g_below
            assign from_below = cells_reg[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_top
            assign from_above = cells_reg[i];
        end
        else
        begin : g_above
            assign from_above = cells_reg[i+1];
        end

        always_ff @(posedge clk)
        begin
            if (cmd.load_req && do_ins)
            begin
                if (CMP_W'(i) == pos_c)
                begin
                    cells_reg[i] <= val;
                end
                else if (CMP_W'(i) > pos_c)
                begin
                    cells_reg[i] <= from_below;
                end
            end
            else if (cmd.load_req && do_del)
            begin
                if (CMP_W'(i) >= pos_c)
                begin
                    cells_reg[i] <= from_above;
                end
            end
        end
    end

    // Traverse read and end-of-run detect
    assign rd_elem   = cells_reg[IDX_W'(trav_idx_reg)];
    assign cnt_l     = LIM_W'(count_reg);
    assign trav_lim  = (cnt_l > LIM_W'(MAX_TRAV)) ? LIM_W'(MAX_TRAV) : cnt_l;
    assign emit_last = ((LIM_W'(trav_idx_reg) + LIM_W'(1)) == trav_lim);
    assign out_free  = !out_valid_reg || m_tready;

    // Next count, traverse index and output register
    always_comb
    begin
        count_next      = count_reg;
        trav_idx_next   = trav_idx_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_elem_next   = out_elem_reg;
        out_idx_next    = out_idx_reg;
        out_cnt_next    = out_cnt_reg;
        out_last_next   = out_last_reg;
        if (cmd.load_req)
        begin
            count_next    = count_after;
            trav_idx_next = '0;
            if (!trav_go)
            begin
                out_valid_next  = 1'b1;
                out_status_next = res_status;
                out_elem_next   = '0;
                out_idx_next    = '0;
                out_cnt_next    = CNT_OUT_W'(count_after);
                out_last_next   = 1'b1;
            end
        end
        else if (cmd.emit_elem)
        begin
            trav_idx_next   = trav_idx_reg + TR_W'(1);
            out_valid_next  = 1'b1;
            out_status_next = ST_OK;
            out_elem_next   = rd_elem;
            out_idx_next    = EIDX_W'(trav_idx_reg);
            out_cnt_next    = CNT_OUT_W'(count_reg);
            out_last_next   = emit_last;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            trav_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            trav_idx_reg  <= trav_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_elem_reg   <= out_elem_next;
        out_idx_reg    <= out_idx_next;
        out_cnt_reg    <= out_cnt_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_cnt_reg, out_idx_reg, out_elem_reg, out_status_reg});
    assign m_tlast  = out_last_reg;

    assign stat.out_free  = out_free;
    assign stat.trav_go   = trav_go;
    assign stat.emit_last = emit_last;

endmodule : pia_datapath
`default_nettype wire

// ----- rtl/pia_checker.sv -----
`default_nettype none
// ============================================================================
// pia_checker: port-level checks for the array core
// Watches the streams and flags results that break the block's rules.
// ============================================================================
module pia_checker
(
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_axis_tready,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready,
    input wire logic [pia_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input wire logic                          m_axis_tlast
);
    import pia_pkg::*;

    logic [STATUS_W-1:0]  m_status;
    logic [ELEM_W-1:0]    m_elem;
    logic [EIDX_W-1:0]    m_idx;
    logic [CNT_OUT_W-1:0] m_cnt;

    assign m_status = m_axis_tdata[STATUS_W-1:0];
    assign m_elem   = m_axis_tdata[STATUS_W +: ELEM_W];
    assign m_idx    = m_axis_tdata[STATUS_W + ELEM_W +: EIDX_W];
    assign m_cnt    = m_axis_tdata[STATUS_W + ELEM_W + EIDX_W +: CNT_OUT_W];

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // Take no request while a result is stalled
    a_no_take_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("request taken while output stalled");

    // Any non-ok status ends its request with zero element fields
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_status != ST_OK) |->
            m_axis_tlast && (m_elem == '0) && (m_idx == '0))
        else $error("error result not single");

    // Empty status only with an empty array
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_status == ST_EMPTY) |-> (m_cnt == '0))
        else $error("empty status with stored elements");

    // Traverse element indices run upward within one run
    a_trav_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast ##1 m_axis_tvalid |->
            (m_idx == $past(m_idx) + EIDX_W'(1)))
        else $error("traverse index out of order");

endmodule : pia_checker

bind positional_insert_delete_array_core pia_checker u_pia_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
